[rtl/core/accel_step_detector_core_defines.svh]
// assertion macros shared by the step detector rtl
// no dependencies; included by the files that carry assertions
`ifndef ACCEL_STEP_DETECTOR_CORE_DEFINES_SVH
`define ACCEL_STEP_DETECTOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define ASD_ASSERT_SAME(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("step detector assertion failed");
`define ASD_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("step detector assertion failed");
`else
`define ASD_ASSERT_SAME(lbl, clk, rst, pre, post)
`define ASD_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

[rtl/core/asd_pkg.sv]
// shared constants, register codes and pipeline control type for the step detector
// no dependencies
package asd_pkg;

   localparam int NUM_AXES_DEF    = 3;
   localparam int MAX_AXES        = 3;
   localparam int SAMPLE_BITS_DEF = 13;
   localparam int FILTER_TAPS     = 4;
   localparam int AXIS_W          = 2;
   localparam int PERIOD_W        = 8;
   localparam int INTERVAL_W      = 8;
   localparam int VPP_CFG_W       = 13;
   localparam int COUNT_W         = 16;
   localparam int HIST_W          = 4;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 13;

   localparam logic [PERIOD_W-1:0]   PERIOD_RESET   = 8'd50;
   localparam logic [INTERVAL_W-1:0] WIN_MIN_RESET  = 8'd10;
   localparam logic [INTERVAL_W-1:0] WIN_MAX_RESET  = 8'd100;
   localparam logic [VPP_CFG_W-1:0]  RUN_VPP_RESET  = 13'd250;
   localparam logic [VPP_CFG_W-1:0]  WALK_VPP_RESET = 13'd100;

   localparam int MIN_RELOAD      = 1024;
   localparam int RUN_DIVISOR     = 50;
   localparam int WALK_PRECISION  = 3;
   localparam int SLOW_PRECISION  = 2;
   localparam int VPP_RESET       = 30;
   localparam int PRECISION_RESET = 5;

   // floor(x / 50) = (x * RECIP_MULT) >> RECIP_SHIFT, exact for x below 43690
   localparam int RECIP_SHIFT = 21;
   localparam int RECIP_W     = 16;
   localparam int RECIP_MULT  = ((1 << RECIP_SHIFT) + RUN_DIVISOR - 1) / RUN_DIVISOR;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_UPDATE_PERIOD = 3'd0,
      CSR_WINDOW_MIN    = 3'd1,
      CSR_WINDOW_MAX    = 3'd2,
      CSR_RUN_VPP       = 3'd3,
      CSR_WALK_VPP      = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic load;    // beat enters the filter stage
      logic adv2;    // item moves into the extremes stage
      logic adv3;    // item moves into the hysteresis stage
      logic update;  // this item closes an update period
   } pipe_ctl_type;

endpackage

[rtl/core/asd_if.sv]
// channel interfaces of the step detector: sample request, result and register write
// depends on asd_pkg
interface asd_req_if #(parameter int SAMPLE_BITS = asd_pkg::SAMPLE_BITS_DEF);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] accel_x;
   logic signed [SAMPLE_BITS-1:0] accel_y;
   logic signed [SAMPLE_BITS-1:0] accel_z;

   modport source (output valid, output accel_x, output accel_y, output accel_z,
                   input ready);
   modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                   output ready);
endinterface

interface asd_rsp_if;
   import asd_pkg::*;
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] step_count;
   logic               step_event;
   logic               rhythm_locked;
   logic [AXIS_W-1:0]  active_axis;

   modport source (output valid, output step_count, output step_event,
                   output rhythm_locked, output active_axis, input ready);
   modport sink   (input valid, input step_count, input step_event,
                   input rhythm_locked, input active_axis, output ready);
endinterface

interface asd_csr_if;
   import asd_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/accel_step_detector_core.sv]
// path: a sample beat passes the filter, extremes, hysteresis and merge registers in turn
// throughput: one sample beat per cycle while the result is taken; four register stages
// (filter, extremes, hysteresis, merge) each hold one item, so a stalled result still lets
// the stages behind it fill; reset: synchronous, active high; clears pipeline valids, sets
// detector state to its reset values and loads the default register values
`include "accel_step_detector_core_defines.svh"

module accel_step_detector_core #(
   parameter int NUM_AXES    = asd_pkg::NUM_AXES_DEF,
   parameter int SAMPLE_BITS = asd_pkg::SAMPLE_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   asd_req_if.sink    req_bus,
   asd_rsp_if.source  rsp_bus,
   asd_csr_if.sink    csr_bus
);
   import asd_pkg::*;

   // register file
   logic [PERIOD_W-1:0]   period_ff, period_in;
   logic [INTERVAL_W-1:0] win_min_ff, win_min_in, win_max_ff, win_max_in;
   logic [VPP_CFG_W-1:0]  run_vpp_ff, run_vpp_in, walk_vpp_ff, walk_vpp_in;
   csr_index_type         csr_idx;

   assign csr_bus.ready = 1'b1;
   assign csr_idx       = csr_index_type'(csr_bus.index);

   always_comb begin
      period_in   = period_ff;
      win_min_in  = win_min_ff;
      win_max_in  = win_max_ff;
      run_vpp_in  = run_vpp_ff;
      walk_vpp_in = walk_vpp_ff;
      if (csr_bus.valid) begin
         unique case (csr_idx)
            CSR_UPDATE_PERIOD: period_in   = csr_bus.data[PERIOD_W-1:0];
            CSR_WINDOW_MIN:    win_min_in  = csr_bus.data[INTERVAL_W-1:0];
            CSR_WINDOW_MAX:    win_max_in  = csr_bus.data[INTERVAL_W-1:0];
            CSR_RUN_VPP:       run_vpp_in  = csr_bus.data[VPP_CFG_W-1:0];
            CSR_WALK_VPP:      walk_vpp_in = csr_bus.data[VPP_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff   <= PERIOD_RESET;
         win_min_ff  <= WIN_MIN_RESET;
         win_max_ff  <= WIN_MAX_RESET;
         run_vpp_ff  <= RUN_VPP_RESET;
         walk_vpp_ff <= WALK_VPP_RESET;
      end else begin
         period_ff   <= period_in;
         win_min_ff  <= win_min_in;
         win_max_ff  <= win_max_in;
         run_vpp_ff  <= run_vpp_in;
         walk_vpp_ff <= walk_vpp_in;
      end
   end

   // pipeline control: each stage moves when the one after it is empty or moving
   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, rsp_valid_ff, rsp_valid_in;
   logic rdy1, rdy2, rdy3, fire0, fire1, fire2, fire3;

   assign rdy3  = !rsp_valid_ff || rsp_bus.ready;
   assign fire3 = v3_ff && rdy3;
   assign rdy2  = !v3_ff || rdy3;
   assign fire2 = v2_ff && rdy2;
   assign rdy1  = !v2_ff || rdy2;
   assign fire1 = v1_ff && rdy1;
   assign req_bus.ready = !v1_ff || rdy1;
   assign fire0 = req_bus.valid && req_bus.ready;

   assign v1_in        = fire0 || (v1_ff && !rdy1);
   assign v2_in        = fire1 || (v2_ff && !rdy2);
   assign v3_in        = fire2 || (v3_ff && !rdy3);
   assign rsp_valid_in = fire3 || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // update period counter, stepped as an item enters the extremes stage
   logic [PERIOD_W-1:0] period_cnt_ff, period_cnt_in, period_cnt_inc;
   logic                period_hit;

   always_comb begin
      period_cnt_inc = period_cnt_ff + 1'b1;
      period_hit     = period_cnt_inc >= period_ff;
      period_cnt_in  = period_cnt_ff;
      if (fire1) begin
         period_cnt_in = period_hit ? '0 : period_cnt_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_cnt_ff <= '0;
      end else begin
         period_cnt_ff <= period_cnt_in;
      end
   end

   pipe_ctl_type ctl;

   assign ctl.load   = fire0;
   assign ctl.adv2   = fire1;
   assign ctl.adv3   = fire2;
   assign ctl.update = period_hit;

   // lanes
   logic signed [SAMPLE_BITS-1:0]        samples [MAX_AXES];
   logic [NUM_AXES-1:0][SAMPLE_BITS-1:0] lane_vpp;
   logic [NUM_AXES-1:0]                  lane_cross;

   assign samples[0] = req_bus.accel_x;
   assign samples[1] = req_bus.accel_y;
   assign samples[2] = req_bus.accel_z;

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
      asd_lane #(
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .sample_i (samples[a]),
         .run_vpp  (run_vpp_ff),
         .walk_vpp (walk_vpp_ff),
         .vpp_o    (lane_vpp[a]),
         .cross_o  (lane_cross[a])
      );
   end

   asd_merge #(
      .NUM_AXES    (NUM_AXES),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_merge (
      .clock           (clock),
      .reset           (reset),
      .adv             (fire3),
      .vpp_i           (lane_vpp),
      .cross_i         (lane_cross),
      .window_min      (win_min_ff),
      .window_max      (win_max_ff),
      .step_count_o    (rsp_bus.step_count),
      .step_event_o    (rsp_bus.step_event),
      .rhythm_locked_o (rsp_bus.rhythm_locked),
      .active_axis_o   (rsp_bus.active_axis)
   );

   assign rsp_bus.valid = rsp_valid_ff;

   `ASD_ASSERT_NEXT(a_accept_fills_s1, clock, reset, fire0, v1_ff)
   `ASD_ASSERT_SAME(a_empty_s1_takes, clock, reset, !v1_ff, req_bus.ready)
   `ASD_ASSERT_NEXT(a_s2_holds_on_stall, clock, reset, v2_ff && !rdy2, v2_ff)

endmodule

[rtl/core/asd_lane.sv]
// one axis lane: magnitude, moving average, extremes tracking, threshold and precision
// update, hysteresis; depends on asd_pkg
module asd_lane #(
   parameter int SAMPLE_BITS = asd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  asd_pkg::pipe_ctl_type              ctl,
   input  logic signed [SAMPLE_BITS-1:0]      sample_i,
   input  logic [asd_pkg::VPP_CFG_W-1:0]      run_vpp,
   input  logic [asd_pkg::VPP_CFG_W-1:0]      walk_vpp,
   output logic [SAMPLE_BITS-1:0]             vpp_o,
   output logic                               cross_o
);
   import asd_pkg::*;

   localparam int W         = SAMPLE_BITS;
   localparam int TAP_SHIFT = $clog2(FILTER_TAPS);
   localparam int SUM_W     = W + TAP_SHIFT;
   localparam int XW        = (W > 11) ? W : 11;   // room for the min reload value
   localparam int CMP_W     = (XW > VPP_CFG_W) ? XW : VPP_CFG_W;
   localparam int PREC_W    = $clog2(((1 << (W - 1)) / RUN_DIVISOR) + 1);
   localparam int PROD_W    = W + RECIP_W;

   // stage 1: magnitude and moving average
   logic [W-1:0]     mag;
   logic [W-1:0]     taps_ff [FILTER_TAPS-1];
   logic [W-1:0]     taps_in [FILTER_TAPS-1];
   logic [SUM_W-1:0] tap_sum;
   logic [W-1:0]     filt1_ff, filt1_in;

   assign mag = sample_i[W-1] ? $unsigned(-sample_i) : $unsigned(sample_i);

   always_comb begin
      tap_sum = SUM_W'(mag);
      for (int k = 0; k < FILTER_TAPS - 1; k++) begin
         tap_sum = tap_sum + SUM_W'(taps_ff[k]);
      end
      filt1_in = tap_sum[SUM_W-1:TAP_SHIFT];
      taps_in  = taps_ff;
      if (ctl.load) begin
         taps_in[0] = mag;
         for (int k = 1; k < FILTER_TAPS - 1; k++) begin
            taps_in[k] = taps_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < FILTER_TAPS - 1; k++) begin
            taps_ff[k] <= (k < 2) ? W'(1) : '0;
         end
      end else begin
         taps_ff <= taps_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         filt1_ff <= filt1_in;
      end
   end

   // stage 2: extremes, peak-to-peak, threshold, slow detection
   logic [XW-1:0] max_ff, max_in, min_ff, min_in;
   logic [XW-1:0] thr_ff, thr_in;
   logic [W-1:0]  vpp_ff, vpp_in;
   logic          slow_ff, slow_in;
   logic [XW-1:0] filt_x, max_n, min_n, vpp_w;
   logic [XW:0]   mm_sum;
   logic [W-1:0]  vpp_n;
   logic          run_hit, walk_hit;
   logic [W-1:0]  filt2_ff;
   logic          upd2_ff, run2_ff;

   always_comb begin
      filt_x   = XW'(filt1_ff);
      max_n    = (filt_x > max_ff) ? filt_x : max_ff;
      min_n    = (filt_x < min_ff) ? filt_x : min_ff;
      vpp_w    = (max_n >= min_n) ? max_n - min_n : '0;
      vpp_n    = vpp_w[W-1:0];
      mm_sum   = {1'b0, max_n} + {1'b0, min_n};
      run_hit  = CMP_W'(vpp_n) >= CMP_W'(run_vpp);
      walk_hit = CMP_W'(vpp_n) >= CMP_W'(walk_vpp);
      max_in   = max_ff;
      min_in   = min_ff;
      thr_in   = thr_ff;
      vpp_in   = vpp_ff;
      slow_in  = slow_ff;
      if (ctl.adv2) begin
         if (ctl.update) begin
            max_in  = '0;
            min_in  = XW'(MIN_RELOAD);
            thr_in  = mm_sum[XW:1];
            vpp_in  = vpp_n;
            slow_in = !run_hit && !walk_hit;
         end else begin
            max_in  = max_n;
            min_in  = min_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff  <= '0;
         min_ff  <= '0;
         thr_ff  <= '0;
         vpp_ff  <= W'(VPP_RESET);
         slow_ff <= 1'b0;
      end else begin
         max_ff  <= max_in;
         min_ff  <= min_in;
         thr_ff  <= thr_in;
         vpp_ff  <= vpp_in;
         slow_ff <= slow_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv2) begin
         filt2_ff <= filt1_ff;
         upd2_ff  <= ctl.update;
         run2_ff  <= run_hit;
      end
   end

   // stage 3: precision and hysteresis; stage 2 state belongs to the item in stage 2 here
   logic [PROD_W-1:0]                 prod;
   logic [PROD_W-RECIP_SHIFT-1:0]     quot;
   logic [PREC_W-1:0]                 prec_ff, prec_in, prec_eff;
   logic [W-1:0]                      held_old_ff, held_old_in, held_new_ff, held_new_in;
   logic [W-1:0]                      diff;
   logic [XW-1:0]                     thr3_ff;
   logic                              slow3_ff;
   logic [W-1:0]                      vpp3_ff;

   assign prod = PROD_W'(vpp_ff) * PROD_W'(RECIP_MULT);
   assign quot = prod[PROD_W-1:RECIP_SHIFT];

   always_comb begin
      if (!upd2_ff) begin
         prec_eff = prec_ff;
      end else if (run2_ff) begin
         prec_eff = quot[PREC_W-1:0];
      end else if (slow_ff) begin
         prec_eff = PREC_W'(SLOW_PRECISION);
      end else begin
         prec_eff = PREC_W'(WALK_PRECISION);
      end
      diff        = (filt2_ff >= held_new_ff) ? filt2_ff - held_new_ff
                                              : held_new_ff - filt2_ff;
      prec_in     = prec_ff;
      held_old_in = held_old_ff;
      held_new_in = held_new_ff;
      if (ctl.adv3) begin
         prec_in     = prec_eff;
         held_old_in = held_new_ff;
         if (diff >= W'(prec_eff)) begin
            held_new_in = filt2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prec_ff     <= PREC_W'(PRECISION_RESET);
         held_old_ff <= '0;
         held_new_ff <= '0;
      end else begin
         prec_ff     <= prec_in;
         held_old_ff <= held_old_in;
         held_new_ff <= held_new_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv3) begin
         thr3_ff  <= thr_ff;
         slow3_ff <= slow_ff;
         vpp3_ff  <= vpp_ff;
      end
   end

   // downward crossing of the threshold, seen on the item held in stage 3
   assign cross_o = (XW'(held_old_ff) >= thr3_ff) && (XW'(held_new_ff) < thr3_ff) && !slow3_ff;
   assign vpp_o   = vpp3_ff;

endmodule

[rtl/core/asd_merge.sv]
// merge stage: picks the most active axis, tests its crossing against the step window,
// keeps the step count and rhythm state and registers the result beat; depends on asd_pkg
`include "accel_step_detector_core_defines.svh"

module asd_merge #(
   parameter int NUM_AXES    = asd_pkg::NUM_AXES_DEF,
   parameter int SAMPLE_BITS = asd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      adv,
   input  logic [NUM_AXES-1:0][SAMPLE_BITS-1:0]      vpp_i,
   input  logic [NUM_AXES-1:0]                       cross_i,
   input  logic [asd_pkg::INTERVAL_W-1:0]            window_min,
   input  logic [asd_pkg::INTERVAL_W-1:0]            window_max,
   output logic [asd_pkg::COUNT_W-1:0]               step_count_o,
   output logic                                      step_event_o,
   output logic                                      rhythm_locked_o,
   output logic [asd_pkg::AXIS_W-1:0]                active_axis_o
);
   import asd_pkg::*;

   logic [SAMPLE_BITS-1:0] best_vpp;
   logic [AXIS_W-1:0]      act;
   logic                   cross_sel;
   logic [INTERVAL_W-1:0]  interval_ff, interval_in, interval_inc;
   logic [HIST_W-1:0]      hist_ff, hist_in, hist_shift;
   logic [COUNT_W-1:0]     total_ff, total_in;
   logic                   locked_ff, locked_in;
   logic                   in_window, event_in;
   logic [COUNT_W-1:0]     count_out_ff;
   logic                   event_out_ff, locked_out_ff;
   logic [AXIS_W-1:0]      axis_out_ff;

   // ties keep the lower axis
   always_comb begin
      best_vpp  = vpp_i[0];
      act       = '0;
      cross_sel = cross_i[0];
      for (int a = 1; a < NUM_AXES; a++) begin
         if (vpp_i[a] > best_vpp) begin
            best_vpp  = vpp_i[a];
            act       = AXIS_W'(a);
            cross_sel = cross_i[a];
         end
      end
   end

   always_comb begin
      interval_inc = (interval_ff == {INTERVAL_W{1'b1}}) ? interval_ff : interval_ff + 1'b1;
      in_window    = (interval_inc > window_min) && (interval_inc < window_max);
      hist_shift   = {hist_ff[HIST_W-2:0], 1'b1};
      interval_in  = interval_ff;
      hist_in      = hist_ff;
      total_in     = total_ff;
      locked_in    = locked_ff;
      event_in     = 1'b0;
      if (adv) begin
         interval_in = interval_inc;
         if (cross_sel) begin
            interval_in = '0;
            if (in_window) begin
               event_in  = 1'b1;
               total_in  = total_ff + 1'b1;
               hist_in   = hist_shift;
               locked_in = locked_ff || (&hist_shift);
            end else begin
               hist_in   = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= '0;
         hist_ff     <= '0;
         total_ff    <= '0;
         locked_ff   <= 1'b0;
      end else begin
         interval_ff <= interval_in;
         hist_ff     <= hist_in;
         total_ff    <= total_in;
         locked_ff   <= locked_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         count_out_ff  <= total_in;
         event_out_ff  <= event_in;
         locked_out_ff <= locked_in;
         axis_out_ff   <= act;
      end
   end

   assign step_count_o    = count_out_ff;
   assign step_event_o    = event_out_ff;
   assign rhythm_locked_o = locked_out_ff;
   assign active_axis_o   = axis_out_ff;

   `ASD_ASSERT_NEXT(a_locked_sticky, clock, reset, locked_ff, locked_ff)
   `ASD_ASSERT_NEXT(a_step_fills_history, clock, reset, adv && event_in, hist_ff[0] && (interval_ff == '0))
   `ASD_ASSERT_NEXT(a_step_bumps_count, clock, reset, adv && event_in, total_ff == $past(total_ff) + 1'b1)

endmodule
